### src/mp2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and types of the 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int MAX_IMAGE  = 256;
  localparam int MAX_WINDOW = 8;
  localparam int MAX_PAD    = 7;
  localparam int ROW_LEN    = MAX_IMAGE + 2 * MAX_PAD;
  localparam int STORE_DEPTH = MAX_WINDOW * ROW_LEN;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int ENTRY_W    = 17;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_WINDOW_SIZE = 2'd1,
    REG_PAD_AMOUNT  = 2'd2,
    REG_STEP_SIZE   = 2'd3
  } reg_idx_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [8:0] n;
    logic [3:0] k;
    logic [2:0] p;
    logic [3:0] s;
    logic [9:0] side;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic signed [15:0] sample;
    logic               valid;
    logic [2:0]         wslot;
    logic [8:0]         wcol;
    logic               trig;
    logic               last;
    logic [2:0]         oslot;
    logic [8:0]         ocol;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] store_addr(logic [2:0] slot, logic [8:0] col);
    store_addr = ADDR_W'(slot) * ADDR_W'(ROW_LEN) + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

### src/mp2d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/mp2d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_front
// Frame position counters; tags each item with padding, window and last info.
// ----------------------------------------------------------------------------
module mp2d_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mp2d_pkg::cfg_t       cfg,
  input  wire logic                 restart,
  input  wire logic                 accept,
  input  wire logic signed [15:0]   sample,
  output mp2d_pkg::cmd_t            cmd
);
  import mp2d_pkg::*;

  logic [8:0] r_r, r_nxt, c_r, c_nxt;
  logic [3:0] rph_r, rph_nxt, cph_r, cph_nxt;
  logic       c_end, r_end;
  logic [9:0] r10, c10;

  assign r10   = {1'b0, r_r};
  assign c10   = {1'b0, c_r};
  assign c_end = (c10 + 10'd1 == cfg.side);
  assign r_end = (r10 + 10'd1 == cfg.side);

  always_comb begin
    c_nxt   = c_end ? 9'd0 : c_r + 9'd1;
    r_nxt   = r_r;
    rph_nxt = rph_r;
    // phase is (pos+1-k) mod s once the window fits
    if ({1'b0, c_nxt} + 10'd1 <= 10'(cfg.k)) cph_nxt = 4'd0;
    else cph_nxt = (cph_r + 4'd1 == cfg.s) ? 4'd0 : cph_r + 4'd1;
    if (c_end) begin
      r_nxt = r_end ? 9'd0 : r_r + 9'd1;
      if ({1'b0, r_nxt} + 10'd1 <= 10'(cfg.k)) rph_nxt = 4'd0;
      else rph_nxt = (rph_r + 4'd1 == cfg.s) ? 4'd0 : rph_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      r_r <= '0; c_r <= '0; rph_r <= '0; cph_r <= '0;
    end else if (accept) begin
      r_r <= r_nxt; c_r <= c_nxt; rph_r <= rph_nxt; cph_r <= cph_nxt;
    end
  end

  always_comb begin
    cmd.sample = sample;
    cmd.valid  = (r10 >= 10'(cfg.p)) && (r10 < 10'(cfg.p) + 10'(cfg.n)) &&
                 (c10 >= 10'(cfg.p)) && (c10 < 10'(cfg.p) + 10'(cfg.n));
    cmd.wslot  = r_r[2:0];
    cmd.wcol   = c_r;
    cmd.trig   = (r10 + 10'd1 >= 10'(cfg.k)) && (rph_r == 4'd0) &&
                 (c10 + 10'd1 >= 10'(cfg.k)) && (cph_r == 4'd0);
    // no further origin fits once pos + s reaches the side
    cmd.last   = (r10 + 10'(cfg.s) >= cfg.side) && (c10 + 10'(cfg.s) >= cfg.side);
    cmd.oslot  = 3'(r_r + 9'd1 - 9'(cfg.k));
    cmd.ocol   = c_r + 9'd1 - 9'(cfg.k);
  end

endmodule
`default_nettype wire

### src/mp2d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module mp2d_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mp2d_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output mp2d_pkg::cmd_t      dout
);
  import mp2d_pkg::*;

  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= din;
  end

endmodule
`default_nettype wire

### src/mp2d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_back
// Writes items to the row store and scans each finished window for its max.
// ----------------------------------------------------------------------------
module mp2d_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         k,
  input  wire logic               q_empty,
  input  wire mp2d_pkg::cmd_t     q_data,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [15:0]      out_window_max,
  output logic                    out_empty_window,
  output logic                    out_last_in_channel
);
  import mp2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] oslot_r, ocol_dy_r, dx_r;
  logic [8:0] ocol_r;
  logic       last_r, pend_r;
  logic signed [15:0] best_r, best_upd;
  logic       any_r, any_upd;
  logic       ovld_r;
  logic [ENTRY_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic       scan_end, out_free;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign scan_end = (ocol_dy_r == 3'(k - 4'd1)) && (dx_r == 3'(k - 4'd1));
  assign raddr    = store_addr(oslot_r + ocol_dy_r, ocol_r + 9'(dx_r));
  assign out_free = !ovld_r || out_pop;

  mp2d_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (q_pop),
    .waddr (store_addr(q_data.wslot, q_data.wcol)),
    .wdata ({q_data.valid, q_data.sample}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    best_upd = best_r;
    any_upd  = any_r;
    if (pend_r && rdata[16]) begin
      if (!any_r || $signed(rdata[15:0]) > best_r) best_upd = $signed(rdata[15:0]);
      any_upd = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_pop && q_data.trig) state_nxt = S_SCAN;
      S_SCAN:  if (scan_end) state_nxt = S_DRAIN;
      S_DRAIN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_SCAN);
      if (state_r == S_DRAIN && out_free) ovld_r <= 1'b1;
      else if (out_pop) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // a new item starts its window from the most negative value
    best_r <= q_pop ? -16'sd32768 : best_upd;
    any_r  <= q_pop ? 1'b0 : any_upd;
    if (q_pop) begin
      oslot_r   <= q_data.oslot;
      ocol_r    <= q_data.ocol;
      last_r    <= q_data.last;
      ocol_dy_r <= '0;
      dx_r      <= '0;
    end else if (state_r == S_SCAN) begin
      if (dx_r == 3'(k - 4'd1)) begin
        dx_r      <= '0;
        ocol_dy_r <= ocol_dy_r + 3'd1;
      end else begin
        dx_r <= dx_r + 3'd1;
      end
    end
    if (state_r == S_DRAIN && out_free) begin
      out_window_max      <= best_upd;
      out_empty_window    <= !any_upd;
      out_last_in_channel <= last_r;
    end
  end

  assign out_empty = !ovld_r;

endmodule
`default_nettype wire

### src/max_pooling_2d_window_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_pooling_2d_window_top
// Square-window max pooling of one padded Q8.8 channel streamed in raster order.
// ----------------------------------------------------------------------------
// Push every position of the padded frame (side image_size + 2*pad_amount),
// padding included. Padding is recognized from the position counters and
// never enters a max. A result item is produced for each window that fits,
// at its bottom-right position; empty_window flags a window of pure padding
// (window_max is then -32768). In the back end an item that closes no window
// takes only its row store write; an item that closes a window holds it for a
// scan of its window_size^2 samples, one sample per cycle through the single
// row store read port, and a drain that waits for output space. A 4-entry
// queue between the position classifier and the back end absorbs bursts. A
// configuration write restarts the frame and must be made while idle.
// ----------------------------------------------------------------------------
module max_pooling_2d_window_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [15:0]      out_window_max,
  output logic                    out_empty_window,
  output logic                    out_last_in_channel
);
  import mp2d_pkg::*;

  logic [8:0] image_size_r;
  logic [3:0] window_size_r, step_size_r;
  logic [2:0] pad_amount_r;
  cfg_t       cfg;
  cmd_t       f_cmd, q_cmd;
  logic       accept, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= 9'd16;
      window_size_r <= 4'd2;
      pad_amount_r  <= 3'd0;
      step_size_r   <= 4'd2;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_SIZE:  image_size_r  <= cfg_data;
        REG_WINDOW_SIZE: window_size_r <= cfg_data[3:0];
        REG_PAD_AMOUNT:  pad_amount_r  <= cfg_data[2:0];
        REG_STEP_SIZE:   step_size_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    cfg.n = (image_size_r == 9'd0) ? 9'd1 :
            (image_size_r > 9'(MAX_IMAGE)) ? 9'(MAX_IMAGE) : image_size_r;
    cfg.k = (window_size_r == 4'd0) ? 4'd1 :
            (window_size_r > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_size_r;
    cfg.p = pad_amount_r;
    cfg.s = (step_size_r == 4'd0) ? 4'd1 : step_size_r;
    cfg.side = 10'(cfg.n) + {6'd0, cfg.p, 1'b0};
  end

  assign accept = in_push && !in_full;

  mp2d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (cfg_we),
    .accept  (accept),
    .sample  (in_sample),
    .cmd     (f_cmd)
  );

  mp2d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (f_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_cmd)
  );

  mp2d_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .k                   (cfg.k),
    .q_empty             (q_empty),
    .q_data              (q_cmd),
    .q_pop               (q_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_window_max      (out_window_max),
    .out_empty_window    (out_empty_window),
    .out_last_in_channel (out_last_in_channel)
  );

endmodule
`default_nettype wire
